FILE: rtl/prrts_pkg.sv
package prrts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int NUM_LOCKS = 8;
    localparam int SLOT_W    = 4;
    localparam int LOCK_W    = 3;
    localparam int PRIO_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = SLOT_W + 1;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SIGN_UP,
        OP_STOP,
        OP_SLEEP,
        OP_SUSPEND,
        OP_RESUME,
        OP_BLOCK,
        OP_YIELD
    } opcode_t;

    typedef enum logic [1:0] {
        ST_SUSPENDED,
        ST_READY,
        ST_SLEEPING,
        ST_BLOCKED
    } task_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_OP,
        CS_WALK,
        CS_FINISH,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        task_state_t         state;
        logic [PRIO_W-1:0]   prio;
        logic [TIME_W-1:0]   wake;
        logic [LOCK_W-1:0]   lock;
    } slot_entry_t;

    typedef struct packed {
        logic                ren;
        logic [SLOT_W-1:0]   raddr;
        logic                wen;
        logic [SLOT_W-1:0]   waddr;
        slot_entry_t         wdata;
    } table_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   run_slot;
        logic                task_running;
        logic                switched;
        logic                none_ready;
        logic                error;
    } result_t;

endpackage

FILE: rtl/prrts_table.sv
module prrts_table
    import prrts_pkg::*;
(
    input  logic        clk,
    input  table_req_t  req,
    output slot_entry_t rdata
);

    slot_entry_t mem [MAX_TASKS];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wen)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.ren)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/prrts_ctrl.sv
module prrts_ctrl
    import prrts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  opcode_t              opcode,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [PRIO_W-1:0]    priority_req,
    input  logic [TIME_W-1:0]    duration_ms,
    input  logic [LOCK_W-1:0]    lock_id,
    input  logic [NUM_LOCKS-1:0] lock_busy,
    input  logic [TIME_W-1:0]    now_ms,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_ack,
    output result_t              res,
    output table_req_t           tbl_req,
    input  slot_entry_t          tbl_rdata
);

    ctrl_state_t state_reg, state_next;

    opcode_t              op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [TIME_W-1:0]    dur_reg;
    logic [LOCK_W-1:0]    lock_reg;
    logic [NUM_LOCKS-1:0] busy_reg;
    logic [TIME_W-1:0]    now_reg;

    logic [MAX_TASKS-1:0] linked_reg;
    logic [SLOT_W-1:0]    cur_reg;
    logic                 cur_valid_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]    eval_idx_reg;
    logic [SLOT_W-1:0]    best_reg;
    logic [PRIO_W-1:0]    max_reg;
    logic                 found_reg;
    logic                 sw_reg;
    logic                 none_reg;
    logic                 err_reg;

    logic [TIME_W:0]      wake_sum;
    logic [TIME_W-1:0]    wake_sat;
    logic                 op_pass;
    logic                 signup_ok;
    logic [SLOT_W-1:0]    rd_idx;
    task_state_t          eval_state;
    logic                 eval_linked;
    logic                 eval_pick;

    assign wake_sum  = {1'b0, now_reg} + {1'b0, dur_reg};
    assign wake_sat  = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];
    assign signup_ok = (prio_reg != '0) && !linked_reg[slot_reg];
    assign rd_idx    = cur_reg + SLOT_W'(1) + cnt_reg[SLOT_W-1:0];

    always_comb
    begin
        unique case (op_reg) inside
            OP_TICK, OP_YIELD, OP_SLEEP: op_pass = 1'b1;
            OP_STOP:                     op_pass = linked_reg[slot_reg];
            default:                     op_pass = 1'b0;
        endcase
    end

    // wake a due sleeper, release a task whose lock is free
    always_comb
    begin
        eval_state  = tbl_rdata.state;
        eval_linked = linked_reg[eval_idx_reg];
        if (eval_state == ST_SLEEPING && now_reg >= tbl_rdata.wake)
        begin
            eval_state = ST_READY;
        end
        if (eval_state == ST_BLOCKED && !busy_reg[tbl_rdata.lock])
        begin
            eval_state = ST_READY;
        end
        eval_pick = eval_linked && eval_state == ST_READY && tbl_rdata.prio > max_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:   if (start) state_next = CS_OP;
            CS_OP:     state_next = op_pass ? CS_WALK : CS_DONE;
            CS_WALK:   if (cnt_reg == CNT_W'(MAX_TASKS)) state_next = CS_FINISH;
            CS_FINISH: state_next = CS_DONE;
            CS_DONE:   if (res_ack) state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        tbl_req       = '0;
        tbl_req.wdata = tbl_rdata;
        idle          = 1'b0;
        res_valid     = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                idle          = 1'b1;
                tbl_req.ren   = start;
                tbl_req.raddr = slot;
            end
            CS_OP:
            begin
                tbl_req.waddr = slot_reg;
                unique case (op_reg)
                    OP_SIGN_UP:
                    begin
                        tbl_req.wen   = signup_ok;
                        tbl_req.wdata = '{state: ST_READY, prio: prio_reg, wake: '0, lock: '0};
                    end
                    OP_SLEEP:
                    begin
                        tbl_req.wen         = 1'b1;
                        tbl_req.wdata.state = ST_SLEEPING;
                        tbl_req.wdata.wake  = wake_sat;
                    end
                    OP_SUSPEND:
                    begin
                        tbl_req.wen         = 1'b1;
                        tbl_req.wdata.state = ST_SUSPENDED;
                    end
                    OP_RESUME:
                    begin
                        tbl_req.wen         = 1'b1;
                        tbl_req.wdata.state = ST_READY;
                    end
                    OP_BLOCK:
                    begin
                        tbl_req.wen         = 1'b1;
                        tbl_req.wdata.state = ST_BLOCKED;
                        tbl_req.wdata.lock  = lock_reg;
                    end
                    default: tbl_req.wen = 1'b0;
                endcase
            end
            CS_WALK:
            begin
                tbl_req.ren         = cnt_reg < CNT_W'(MAX_TASKS);
                tbl_req.raddr       = rd_idx;
                tbl_req.waddr       = eval_idx_reg;
                tbl_req.wdata.state = eval_state;
                tbl_req.wen         = cnt_reg != '0 && eval_linked
                                      && eval_state != tbl_rdata.state;
            end
            CS_FINISH: idle = 1'b0;
            CS_DONE:   res_valid = 1'b1;
            default:   idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            linked_reg    <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CS_OP)
            begin
                if (op_reg == OP_SIGN_UP && signup_ok)
                begin
                    linked_reg[slot_reg] <= 1'b1;
                end
                if (op_reg == OP_STOP)
                begin
                    linked_reg[slot_reg] <= 1'b0;
                end
            end
            if (state_reg == CS_FINISH)
            begin
                if (found_reg)
                begin
                    cur_reg       <= best_reg;
                    cur_valid_reg <= 1'b1;
                end
                else if (!linked_reg[cur_reg])
                begin
                    cur_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    op_reg   <= opcode;
                    slot_reg <= slot;
                    prio_reg <= priority_req;
                    dur_reg  <= duration_ms;
                    lock_reg <= lock_id;
                    busy_reg <= lock_busy;
                    now_reg  <= now_ms;
                    sw_reg   <= 1'b0;
                    none_reg <= 1'b0;
                    err_reg  <= 1'b0;
                end
            end
            CS_OP:
            begin
                err_reg   <= op_reg == OP_SIGN_UP && !signup_ok;
                cnt_reg   <= '0;
                max_reg   <= '0;
                found_reg <= 1'b0;
            end
            CS_WALK:
            begin
                cnt_reg      <= cnt_reg + CNT_W'(1);
                eval_idx_reg <= rd_idx;
                if (cnt_reg != '0 && eval_pick)
                begin
                    max_reg   <= tbl_rdata.prio;
                    best_reg  <= eval_idx_reg;
                    found_reg <= 1'b1;
                end
            end
            CS_FINISH:
            begin
                none_reg <= !found_reg;
                sw_reg   <= found_reg && (!cur_valid_reg || best_reg != cur_reg);
            end
            default: ;
        endcase
    end

    assign res = '{run_slot: cur_reg, task_running: cur_valid_reg, switched: sw_reg,
                   none_ready: none_reg, error: err_reg};

endmodule

FILE: rtl/priority_round_robin_task_scheduler.sv
// Task scheduler for one core with up to sixteen task slots.
// Request channel (req_valid/req_stall) carries one command word: opcode,
// slot, priority_req, duration_ms, lock_id, lock_busy and now_ms.
// Response channel (rsp_valid/rsp_stall) returns one word per command:
// run_slot, task_running, switched, none_ready and error.
// Commands without a scheduling pass (sign up, suspend, resume, block,
// stop of an unlinked slot) skip the table walk and go straight to the response.
// Tick, yield, sleep and stop of a linked slot walk the slot table one
// entry per cycle through its single read port.
// One command is in work at a time; req_stall is high while it runs.
// A finished response waits in the output register, so the next command
// is taken while the receiver stalls; the command after that holds until
// the register drains.
// Reset clears all slot links and the running task; no clearing pass.
module priority_round_robin_task_scheduler
    import prrts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [2:0]           opcode,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [PRIO_W-1:0]    priority_req,
    input  logic [TIME_W-1:0]    duration_ms,
    input  logic [LOCK_W-1:0]    lock_id,
    input  logic [NUM_LOCKS-1:0] lock_busy,
    input  logic [TIME_W-1:0]    now_ms,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [SLOT_W-1:0]    run_slot,
    output logic                 task_running,
    output logic                 switched,
    output logic                 none_ready,
    output logic                 error
);

    logic        idle;
    logic        start;
    logic        res_valid;
    logic        load;
    result_t     res;
    table_req_t  tbl_req;
    slot_entry_t tbl_rdata;

    logic        rsp_valid_reg;
    result_t     rsp_reg;

    assign req_stall = !idle;
    assign start     = req_valid && idle;
    assign load      = res_valid && (!rsp_valid_reg || !rsp_stall);

    prrts_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    prrts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode_t'(opcode)),
        .slot         (slot),
        .priority_req (priority_req),
        .duration_ms  (duration_ms),
        .lock_id      (lock_id),
        .lock_busy    (lock_busy),
        .now_ms       (now_ms),
        .idle         (idle),
        .res_valid    (res_valid),
        .res_ack      (load),
        .res          (res),
        .tbl_req      (tbl_req),
        .tbl_rdata    (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign run_slot     = rsp_reg.run_slot;
    assign task_running = rsp_reg.task_running;
    assign switched     = rsp_reg.switched;
    assign none_ready   = rsp_reg.none_ready;
    assign error        = rsp_reg.error;

endmodule
